// ===== design/drhp_pkg.sv =====
// Package for the disk rim height profile block: constants, register indexes,
// status codes and the sine polynomial coefficients. No dependencies.
`default_nettype none
package drhp_pkg;
    localparam int MAX_POINTS = 16;
    localparam int PIW        = $clog2(MAX_POINTS);
    localparam int PCW        = PIW + 1;

    localparam logic [2:0] REG_OUTER  = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HMAX   = 3'd2;
    localparam logic [2:0] REG_HMIN   = 3'd3;
    localparam logic [2:0] REG_PEAK   = 3'd4;
    localparam logic [2:0] REG_PMODE  = 3'd5;
    localparam logic [2:0] REG_PCOUNT = 3'd6;

    localparam logic [1:0] ST_EVAL  = 2'd0;
    localparam logic [1:0] ST_NOSEG = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    localparam logic [31:0] SC1 = 32'd1686629713;
    localparam logic [31:0] SC3 = 32'd693598669;
    localparam logic [31:0] SC5 = 32'd85569306;
    localparam logic [31:0] SC7 = 32'd5026995;
    localparam logic [31:0] SC9 = 32'd172272;
    localparam logic [31:0] Q30_ONE = 32'h4000_0000;
endpackage
`default_nettype wire

// ===== design/disk_rim_height_profile.sv =====
// Top level of the disk rim height profile block: control sequencer, point
// table memory, shift-and-add multiplier, restoring divider and square root.
// Depends on drhp_pkg.
//
// Evaluates rim height at (radius, azimuth), one word at a time. A table write
// (mode 0) answers in the cycle after it is accepted. An evaluation checks the
// annulus and then either walks the point table, followed by two 17-bit products
// and a division, or runs the sine polynomial through the bit-serial multiplier
// (six products: z*z, four Horner steps and the final p*z) and forms the peak
// height from two 32x32 products. The ellipse then takes two products, a square
// root, one product and a division. All multiplies, divisions and the root go
// one bit (root: two bits) per cycle through shared shift-and-add /
// shift-and-subtract logic. A table of a single point gives its height without
// the walk or the products. Items outside the annulus answer with a zero height,
// and an uncovered angle answers with the no-segment status once every entry has
// been visited.
// The result is held in an output register until taken; the next word is taken
// once that register is free.
`default_nettype none
module disk_rim_height_profile (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: radius[31:0], azimuth[47:32], point_index[51:48],
    //        point_angle[67:52], point_height[99:68], zero pad to 104
    input  wire logic [103:0] s_axis_tdata,
    // tuser: mode
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: height[31:0], status[33:32], zero pad to 40
    output logic [39:0]      m_axis_tdata
);
    import drhp_pkg::*;

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHK   = 5'd1;
    localparam logic [4:0] S_POLY  = 5'd2;   // Horner steps
    localparam logic [4:0] S_POLYR = 5'd3;
    localparam logic [4:0] S_SINA  = 5'd4;   // hmax product setup
    localparam logic [4:0] S_SINB  = 5'd5;   // hmax and hmin products
    localparam logic [4:0] S_SINC  = 5'd6;
    localparam logic [4:0] S_TRD   = 5'd7;   // table read
    localparam logic [4:0] S_TCMP  = 5'd8;
    localparam logic [4:0] S_TMA   = 5'd9;
    localparam logic [4:0] S_TMB   = 5'd10;
    localparam logic [4:0] S_TDIV  = 5'd11;
    localparam logic [4:0] S_ESQ1  = 5'd12;  // w*w setup
    localparam logic [4:0] S_ESQ2  = 5'd13;  // w*w and d*d
    localparam logic [4:0] S_SQRT  = 5'd14;
    localparam logic [4:0] S_EMUL  = 5'd15;
    localparam logic [4:0] S_EDIV  = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;
    localparam logic [4:0] S_TRD2  = 5'd18;
    localparam logic [4:0] S_TWAIT = 5'd19;

    logic [4:0]  r_st;
    logic [31:0] r_outer, r_width, r_hmax, r_hmin;
    logic [15:0] r_peak;
    logic        r_pmode;
    logic [4:0]  r_pcount;

    logic [31:0] r_a;
    logic [15:0] r_zeta;
    logic [PCW-1:0] r_n;

    logic [15:0] angle_mem [MAX_POINTS];
    logic [31:0] height_mem [MAX_POINTS];
    logic [PIW-1:0] r_raddr;
    logic [15:0] r_rang;
    logic [31:0] r_rhgt;

    // serial arithmetic
    logic [63:0] r_acc;     // product / remainder
    logic [63:0] r_x;       // multiplicand / dividend / root operand
    logic [63:0] r_y;       // multiplier / divisor
    logic [6:0]  r_cnt;
    logic [63:0] r_tmp;     // saved value
    logic [63:0] r_q;       // quotient / root
    logic [2:0]  r_step;
    logic [31:0] r_z;
    logic [31:0] r_z2;
    logic        r_neg;
    logic [31:0] r_c;       // |cos| in Q30
    logic [15:0] r_lo;
    logic [16:0] r_span;
    logic [15:0] r_t;
    logic [31:0] r_hlo;
    logic [31:0] r_hz;
    logic [PCW-1:0] r_i;

    logic [31:0] r_oh;
    logic [1:0]  r_os;
    logic        r_ov;

    assign s_axis_tready = (r_st == S_IDLE) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {6'd0, r_os, r_oh};

    wire logic acc_in = s_axis_tvalid && s_axis_tready;

    // one restoring division step
    logic [64:0] div_rem;
    logic        div_ok;
    always_comb begin
        div_rem = {r_acc, r_x[63]} - {1'b0, r_y};
        div_ok  = !div_rem[64];
    end
    // one square-root step: remainder r_acc, root r_q
    logic [65:0] sq_trial;
    logic [65:0] sq_rem;
    always_comb begin
        sq_rem   = {r_acc, r_x[63:62]};
        sq_trial = sq_rem - {r_q[63:0], 2'b01};
    end

    wire logic [15:0] sin_d = r_zeta - r_peak;
    wire logic [13:0] sin_r = sin_d[13:0];
    wire logic [15:0] sin_m = (sin_d[14]) ? {2'b0, sin_r} : (16'd16384 - {2'd0, sin_r});
    logic [31:0] coef;
    always_comb begin
        unique case (r_step)
            3'd0:    coef = SC7;
            3'd1:    coef = SC5;
            3'd2:    coef = SC3;
            default: coef = SC1;
        endcase
    end

    wire logic last_pt = ({1'b0, r_i} + 1'b1) >= {1'b0, r_n};
    wire logic [63:0] w64 = {32'd0, r_width};
    wire logic [31:0] dd  = r_outer - r_a;

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OUTER:  r_outer  <= i_cfg_data;
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HMAX:   r_hmax   <= i_cfg_data;
                REG_HMIN:   r_hmin   <= i_cfg_data;
                REG_PEAK:   r_peak   <= i_cfg_data[15:0];
                REG_PMODE:  r_pmode  <= i_cfg_data[0];
                REG_PCOUNT: r_pcount <= i_cfg_data[4:0];
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            r_outer <= '0; r_width <= 32'd65536; r_hmax <= '0; r_hmin <= '0;
            r_peak <= '0; r_pmode <= 1'b0; r_pcount <= 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in && !s_axis_tuser) begin
            angle_mem[s_axis_tdata[51:48]]  <= s_axis_tdata[67:52];
            height_mem[s_axis_tdata[51:48]] <= s_axis_tdata[99:68];
        end
        r_rang <= angle_mem[r_raddr];
        r_rhgt <= height_mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (acc_in) begin
                    r_a    <= s_axis_tdata[31:0];
                    r_zeta <= s_axis_tdata[47:32];
                    if (!s_axis_tuser) begin
                        r_oh <= '0; r_os <= ST_WRITE; r_ov <= 1'b1;
                    end else r_st <= S_CHK;
                end
                S_CHK: begin
                    if (($signed({2'b0, r_a}) < $signed({2'b0, r_outer}) -
                         $signed({2'b0, r_width})) || (r_a > r_outer)) begin
                        r_oh <= '0; r_os <= ST_EVAL; r_st <= S_OUT;
                    end else if (!r_pmode) begin
                        r_z  <= {14'd0, sin_m, 2'b0};
                        r_x  <= {14'd0, sin_m, 2'b0, 32'd0} >> 32;
                        r_y  <= {14'd0, sin_m, 2'b0, 32'd0} >> 32;
                        r_neg <= sin_d[15] ^ sin_d[14];
                        r_acc <= '0; r_cnt <= '0; r_step <= 3'd7;
                        r_tmp <= {32'd0, SC9};
                        r_st <= S_POLY;
                    end else begin
                        if (r_pcount == 5'd0) r_n <= PCW'(1);
                        else if (r_pcount > 5'(MAX_POINTS)) r_n <= PCW'(MAX_POINTS);
                        else r_n <= PCW'(r_pcount);
                        r_i <= '0; r_raddr <= '0;
                        r_st <= S_TRD;
                    end
                end
                // serial product r_acc = r_x * r_y over 32 bits of r_y
                S_POLY: begin
                    if (r_cnt == 7'd32) begin
                        r_cnt <= '0;
                        r_st <= S_POLYR;
                    end else begin
                        if (r_y[0]) r_acc <= (r_acc >> 1) + {1'b0, r_x[31:0], 31'd0};
                        else r_acc <= r_acc >> 1;
                        r_y <= r_y >> 1;
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_POLYR: begin
                    // r_acc holds the full product after 32 shifts
                    unique case (r_step)
                        3'd7: begin   // z2 = z*z >> 16
                            r_z2 <= r_acc[47:16];
                            r_x <= r_tmp; r_y <= {32'd0, r_acc[47:16]};
                            r_step <= 3'd0;
                        end
                        3'd4: begin   // final p*z >> 16
                            if (r_acc[47:16] > Q30_ONE) r_c <= Q30_ONE;
                            else r_c <= r_acc[47:16];
                            r_step <= 3'd5;
                        end
                        default: begin
                            r_tmp <= {32'd0, coef - r_acc[47:16]};
                            r_x <= {32'd0, coef - r_acc[47:16]};
                            if (r_step == 3'd3) r_y <= {32'd0, r_z};
                            else r_y <= {32'd0, r_z2};
                            r_step <= r_step + 3'd1;
                        end
                    endcase
                    r_acc <= '0;
                    if (r_step == 3'd4) begin
                        r_st <= S_SINA;
                    end else r_st <= S_POLY;
                    if (r_step == 3'd4) begin
                        r_x <= {32'd0, r_hmax};
                        r_y <= '0;
                        r_tmp <= '0;
                    end
                end
                S_SINA: begin
                    // set up hmax*(1+c) where c signed
                    r_x <= {32'd0, r_hmax};
                    r_y <= r_neg ? {32'd0, Q30_ONE - r_c} : {32'd0, Q30_ONE + r_c};
                    r_acc <= '0; r_cnt <= '0; r_step <= 3'd0;
                    r_st <= S_SINB;
                end
                S_SINB: begin
                    if (r_cnt == 7'd32) begin
                        r_cnt <= '0;
                        if (r_step == 3'd0) begin
                            r_tmp <= r_acc;
                            r_acc <= '0;
                            r_x <= {32'd0, r_hmin};
                            r_y <= r_neg ? {32'd0, Q30_ONE + r_c} : {32'd0, Q30_ONE - r_c};
                            r_step <= 3'd1;
                        end else r_st <= S_SINC;
                    end else begin
                        if (r_y[0]) r_acc <= (r_acc >> 1) + {1'b0, r_x[31:0], 31'd0};
                        else r_acc <= r_acc >> 1;
                        r_y <= r_y >> 1;
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_SINC: begin
                    // (pa + pb + 2^30) >> 31, rounded to nearest
                    r_hz <= 32'(({1'b0, r_tmp} + {1'b0, r_acc} + 65'h4000_0000) >> 31);
                    r_st <= S_ESQ1;
                end
                S_TRD: r_st <= S_TRD2;
                S_TRD2: begin
                    r_lo <= r_rang; r_hlo <= r_rhgt;
                    if (r_n == PCW'(1)) begin
                        r_hz <= r_rhgt; r_st <= S_ESQ1;
                    end else if (last_pt) begin
                        r_raddr <= '0; r_span <= 17'h10000 - {1'b0, r_rang};
                        r_st <= S_TWAIT;
                    end else begin
                        r_raddr <= r_i[PIW-1:0] + PIW'(1);
                        r_st <= S_TWAIT;
                    end
                end
                S_TWAIT: r_st <= S_TCMP;
                S_TCMP: begin
                    // r_rang/r_rhgt now hold the upper point
                    logic [16:0] hi;
                    hi = last_pt ? 17'h10000 : {1'b0, r_rang};
                    if ({1'b0, r_zeta} >= {1'b0, r_lo} && {1'b0, r_zeta} < hi) begin
                        r_span <= hi - {1'b0, r_lo};
                        r_t <= r_zeta - r_lo;
                        r_tmp <= {32'd0, r_rhgt};
                        r_x <= {32'd0, r_hlo};
                        r_y <= {47'd0, hi - {1'b0, r_lo}} - {48'd0, r_zeta - r_lo};
                        r_acc <= '0; r_cnt <= '0;
                        r_st <= S_TMA;
                    end else if (last_pt) begin
                        r_oh <= '0; r_os <= ST_NOSEG; r_st <= S_OUT;
                    end else begin
                        r_i <= r_i + PCW'(1);
                        r_raddr <= r_i[PIW-1:0] + PIW'(1);
                        r_st <= S_TRD;
                    end
                end
                S_TMA: begin   // hlo*(span-t), 17 bits of multiplier
                    if (r_cnt == 7'd17) begin
                        r_q <= r_acc >> 15;  // 17 steps leave the product scaled by 2^15
                        r_acc <= '0; r_cnt <= '0;
                        r_x <= r_tmp; r_y <= {48'd0, r_t};
                        r_st <= S_TMB;
                    end else begin
                        if (r_y[0]) r_acc <= (r_acc >> 1) + {1'b0, r_x[31:0], 31'd0};
                        else r_acc <= r_acc >> 1;
                        r_y <= r_y >> 1;
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_TMB: begin
                    if (r_cnt == 7'd17) begin
                        // dividend = a + b + span/2, divide by span
                        r_x <= r_q + (r_acc >> 15) + {48'd0, r_span[16:1]};
                        r_y <= {47'd0, r_span};
                        r_acc <= '0; r_cnt <= '0; r_q <= '0;
                        r_st <= S_TDIV;
                    end else begin
                        if (r_y[0]) r_acc <= (r_acc >> 1) + {1'b0, r_x[31:0], 31'd0};
                        else r_acc <= r_acc >> 1;
                        r_y <= r_y >> 1;
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_TDIV, S_EDIV: begin
                    if (r_cnt == 7'd64) begin
                        r_cnt <= '0;
                        if (r_st == S_TDIV) begin
                            r_hz <= r_q[31:0]; r_st <= S_ESQ1;
                        end else begin
                            r_oh <= r_q[31:0]; r_os <= ST_EVAL; r_st <= S_OUT;
                        end
                    end else begin
                        if (div_ok) r_acc <= div_rem[63:0];
                        else r_acc <= {r_acc[62:0], r_x[63]};
                        r_q <= {r_q[62:0], div_ok};
                        r_x <= r_x << 1;
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_ESQ1: begin
                    if (r_width == 32'd0) begin
                        r_oh <= r_hz; r_os <= ST_EVAL; r_st <= S_OUT;
                    end else begin
                        r_x <= w64; r_y <= w64; r_acc <= '0; r_cnt <= '0;
                        r_step <= 3'd0; r_st <= S_ESQ2;
                    end
                end
                S_ESQ2: begin
                    if (r_cnt == 7'd32) begin
                        r_cnt <= '0;
                        if (r_step == 3'd0) begin
                            r_tmp <= r_acc;
                            r_acc <= '0; r_x <= {32'd0, dd}; r_y <= {32'd0, dd};
                            r_step <= 3'd1;
                        end else begin
                            r_x <= r_tmp - r_acc;
                            r_acc <= '0; r_q <= '0;
                            r_st <= S_SQRT;
                        end
                    end else begin
                        if (r_y[0]) r_acc <= (r_acc >> 1) + {1'b0, r_x[31:0], 31'd0};
                        else r_acc <= r_acc >> 1;
                        r_y <= r_y >> 1;
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_SQRT: begin   // two operand bits per cycle
                    if (r_cnt == 7'd32) begin
                        r_cnt <= '0;
                        r_x <= {32'd0, r_hz}; r_y <= r_q; r_acc <= '0;
                        r_st <= S_EMUL;
                    end else begin
                        if (!sq_trial[65]) begin
                            r_acc <= sq_trial[63:0];
                            r_q <= {r_q[62:0], 1'b1};
                        end else begin
                            r_acc <= sq_rem[63:0];
                            r_q <= {r_q[62:0], 1'b0};
                        end
                        r_x <= r_x << 2;
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_EMUL: begin
                    if (r_cnt == 7'd32) begin
                        r_cnt <= '0;
                        r_x <= r_acc + {33'd0, r_width[31:1]};
                        r_y <= w64; r_acc <= '0; r_q <= '0;
                        r_st <= S_EDIV;
                    end else begin
                        if (r_y[0]) r_acc <= (r_acc >> 1) + {1'b0, r_x[31:0], 31'd0};
                        else r_acc <= r_acc >> 1;
                        r_y <= r_y >> 1;
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_OUT: if (!r_ov) begin
                    r_ov <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
